FILE: sv/p192_pkg.sv
package p192_pkg;

	localparam int NSTG = 11;

	typedef logic [NSTG:1] stg_en_t;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_SQR = 3'd3,
		OP_NEG = 3'd4
	} op_t;

	localparam logic [191:0] P_PRIME =
		192'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFFFF_FFFFFFFF;
	// 2^192 mod p, also -p mod 2^192
	localparam logic [191:0] K_FOLD =
		192'h00000000_00000000_00000000_00000001_00000000_00000001;

endpackage

FILE: sv/p192_lin.sv
module p192_lin (
	input  logic                  clk,
	input  p192_pkg::stg_en_t     en,
	input  logic [2:0]            op_s1,
	input  logic [191:0]          a_s1,
	input  logic [191:0]          b_s1,
	output logic [191:0]          lin_s3
);
	import p192_pkg::*;

	logic [191:0] res_s2;
	logic         flag_s2;
	logic [2:0]   op_s2;
	logic [192:0] sum;
	logic [192:0] dif;

	assign sum = {1'b0, a_s1} + {1'b0, b_s1};
	assign dif = {1'b0, a_s1} - {1'b0, b_s1};

	always_ff @(posedge clk) begin
		if (en[2]) begin
			op_s2 <= op_s1;
			case (op_s1)
				OP_ADD: begin
					res_s2  <= sum[191:0];
					flag_s2 <= sum[192] || (sum[191:0] >= P_PRIME);
				end
				OP_SUB: begin
					res_s2  <= dif[191:0];
					flag_s2 <= dif[192];
				end
				OP_NEG: begin
					res_s2  <= P_PRIME - a_s1;
					flag_s2 <= (a_s1 == '0);
				end
				default: begin
					res_s2  <= '0;
					flag_s2 <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			case (op_s2)
				OP_ADD:  lin_s3 <= flag_s2 ? res_s2 + K_FOLD : res_s2;
				OP_SUB:  lin_s3 <= flag_s2 ? res_s2 - K_FOLD : res_s2;
				OP_NEG:  lin_s3 <= flag_s2 ? '0 : res_s2;
				default: lin_s3 <= '0;
			endcase
		end
	end

endmodule

FILE: sv/p192_mul.sv
module p192_mul (
	input  logic                  clk,
	input  p192_pkg::stg_en_t     en,
	input  logic [191:0]          a_s1,
	input  logic [191:0]          b_s1,
	output logic [383:0]          c_s6
);
	import p192_pkg::*;

	logic [63:0]  pp_s2 [6][6];
	logic [223:0] row_s3 [6];
	logic [255:0] pr_s4 [3];
	logic [319:0] q_s5;
	logic [255:0] p2_s5;

	// 32x32 partial products, one bank per cycle while stage 2 is enabled
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < 6; i++) begin
				for (int j = 0; j < 6; j++) begin
					pp_s2[i][j] <= 64'(a_s1[32*i +: 32]) * 64'(b_s1[32*j +: 32]);
				end
			end
		end
	end

	// the even columns of a row do not overlap each other, nor do the odd ones
	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int i = 0; i < 6; i++) begin
				row_s3[i] <= 224'({pp_s2[i][4], pp_s2[i][2], pp_s2[i][0]})
					+ {pp_s2[i][5], pp_s2[i][3], pp_s2[i][1], 32'd0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int k = 0; k < 3; k++) begin
				pr_s4[k] <= 256'(row_s3[2*k]) + {row_s3[2*k+1], 32'd0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			q_s5  <= 320'(pr_s4[0]) + {pr_s4[1], 64'd0};
			p2_s5 <= pr_s4[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			c_s6 <= 384'(q_s5) + {p2_s5, 128'd0};
		end
	end

endmodule

FILE: sv/p192_red.sv
module p192_red (
	input  logic                  clk,
	input  p192_pkg::stg_en_t     en,
	input  logic [383:0]          c_s6,
	output logic [191:0]          v_s10
);
	import p192_pkg::*;

	logic [193:0] ta_s7;
	logic [63:0]  c5_s7;
	logic [193:0] t_s8;
	logic [192:0] u_s9;

	// low + (c5,c4,c3) + (c4,c3,0), then + (0,c5,c5)
	always_ff @(posedge clk) begin
		if (en[7]) begin
			ta_s7 <= 194'(c_s6[191:0]) + 194'(c_s6[383:192])
				+ 194'({c_s6[319:192], 64'd0});
			c5_s7 <= c_s6[383:320];
		end
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			t_s8 <= ta_s7 + 194'({c5_s7, c5_s7});
		end
	end

	// fold the top two bits back as H * (2^64 + 1)
	always_ff @(posedge clk) begin
		if (en[9]) begin
			u_s9 <= 193'(t_s8[191:0]) + 193'({t_s8[193:192], 62'd0, t_s8[193:192]});
		end
	end

	// second wrap cannot carry again: low part is tiny then
	always_ff @(posedge clk) begin
		if (en[10]) begin
			v_s10 <= u_s9[192] ? u_s9[191:0] + K_FOLD : u_s9[191:0];
		end
	end

endmodule

FILE: sv/p192_field_arith_unit.sv
// Channel  Signals                                    Direction
// request  in_valid, in_stall, req_type, a_*, b_*     into the block
// result   out_valid, out_stall, r_low, r_mid, r_high out of the block
//
// Every operation passes through the 11-stage pipeline (32x32 product bank,
// adder tree, P-192 fold, final correction); one request can enter each
// cycle while in_stall is low.
// Reset clears only the stage valid bits.
// Each stage holds when it is full and the next one cannot take its data,
// so bubbles are squeezed out and a stalled result never blocks empty stages.
module p192_field_arith_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [63:0] a_low,
	input  logic [63:0] a_mid,
	input  logic [63:0] a_high,
	input  logic [63:0] b_low,
	input  logic [63:0] b_mid,
	input  logic [63:0] b_high,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] r_low,
	output logic [63:0] r_mid,
	output logic [63:0] r_high
);
	import p192_pkg::*;

	stg_en_t      en;
	logic [NSTG:1] vld_q;
	logic [2:0]   op_s1;
	logic [191:0] a_s1;
	logic [191:0] b_s1;
	logic [2:0]   op_pipe_s [2:10];
	logic [191:0] lin_s3;
	logic [191:0] lin_pipe_s [4:10];
	logic [383:0] c_s6;
	logic [191:0] v_s10;
	logic [191:0] r_s11;

	always_comb begin
		en[NSTG] = !vld_q[NSTG] || !out_stall;
		for (int k = NSTG - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign in_stall  = !en[1];
	assign out_valid = vld_q[NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) vld_q[1] <= in_valid;
			for (int k = 2; k <= NSTG; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			op_s1 <= req_type;
			a_s1  <= {a_high, a_mid, a_low};
			b_s1  <= (req_type == OP_SQR) ? {a_high, a_mid, a_low}
				: {b_high, b_mid, b_low};
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) op_pipe_s[2] <= op_s1;
		for (int k = 3; k <= 10; k++) begin
			if (en[k]) op_pipe_s[k] <= op_pipe_s[k-1];
		end
		if (en[4]) lin_pipe_s[4] <= lin_s3;
		for (int k = 5; k <= 10; k++) begin
			if (en[k]) lin_pipe_s[k] <= lin_pipe_s[k-1];
		end
	end

	p192_lin u_lin (
		.clk    (clk),
		.en     (en),
		.op_s1  (op_s1),
		.a_s1   (a_s1),
		.b_s1   (b_s1),
		.lin_s3 (lin_s3)
	);

	p192_mul u_mul (
		.clk  (clk),
		.en   (en),
		.a_s1 (a_s1),
		.b_s1 (b_s1),
		.c_s6 (c_s6)
	);

	p192_red u_red (
		.clk   (clk),
		.en    (en),
		.c_s6  (c_s6),
		.v_s10 (v_s10)
	);

	always_ff @(posedge clk) begin
		if (en[11]) begin
			case (op_pipe_s[10])
				OP_MUL, OP_SQR: r_s11 <= (v_s10 >= P_PRIME) ? v_s10 + K_FOLD : v_s10;
				default:        r_s11 <= lin_pipe_s[10];
			endcase
		end
	end

	assign r_low  = r_s11[63:0];
	assign r_mid  = r_s11[127:64];
	assign r_high = r_s11[191:128];

`ifndef SYNTHESIS
	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[1] |-> !in_stall)
		else $error("request stalled with empty first stage");
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_q[1])
		else $error("accepted request lost at first stage");
	a_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[NSTG-1] && en[NSTG] |=> vld_q[NSTG])
		else $error("item lost entering output stage");
`endif

endmodule
